/* rtl/core/mhgr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhgr_pkg: shared types and constants
// Item kinds, register indexes and controller states for the grid rasteriser.
// ----------------------------------------------------------------------------
package mhgr_pkg;

  localparam int KIND_W  = 2;
  localparam int RIDX_W  = 3;
  localparam int CFG_W   = 32;
  localparam int CSIZE_W = 20;
  localparam int GDIM_W  = 9;

  typedef enum logic [KIND_W-1:0] {
    KIND_POINT = 2'd0,
    KIND_READ  = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [RIDX_W-1:0] {
    REG_MIN_X    = 3'd0,
    REG_MIN_Y    = 3'd1,
    REG_BIN_SIZE = 3'd2,
    REG_ROWS     = 3'd3,
    REG_COLS     = 3'd4
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_DIV,
    ST_RD,
    ST_WB,
    ST_CLR,
    ST_OUT
  } state_t;

endpackage

/* rtl/core/mhgr_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhgr_in_if / mhgr_out_if: valid/ready channels
// Input items and result items of the grid rasteriser.
// ----------------------------------------------------------------------------
interface mhgr_in_if #(parameter int COORD_BITS = 32);
  logic                         valid;
  logic                         ready;
  logic [1:0]                   kind;
  logic signed [COORD_BITS-1:0] x_coord;
  logic signed [COORD_BITS-1:0] y_coord;
  logic signed [COORD_BITS-1:0] z_coord;
  logic [7:0]                   read_row;
  logic [7:0]                   read_col;
  modport source (output valid, kind, x_coord, y_coord, z_coord, read_row, read_col,
                  input ready);
  modport sink (input valid, kind, x_coord, y_coord, z_coord, read_row, read_col,
                output ready);
endinterface

interface mhgr_out_if;
  logic               valid;
  logic               ready;
  logic [7:0]         cell_row;
  logic [7:0]         cell_col;
  logic signed [31:0] cell_min_z;
  logic               cell_valid;
  logic               lowered;
  modport source (output valid, cell_row, cell_col, cell_min_z, cell_valid, lowered,
                  input ready);
  modport sink (input valid, cell_row, cell_col, cell_min_z, cell_valid, lowered,
                output ready);
endinterface

/* rtl/core/min_height_grid_rasterizer_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_height_grid_rasterizer_unit: lowest height per grid cell
// Bins points into a row/column grid and keeps the minimum height per cell.
// ----------------------------------------------------------------------------
// One transaction at a time. For a point, the column and row come from two
// iterative floor dividers running side by side, each W bits wide, W being
// COORD_BITS+3 (never below 34), one quotient bit a cycle; then the cell is
// read from the height and valid RAMs, written back in the next cycle, and
// the result is offered the cycle after. A read item goes through the RAM
// read and the result register without the dividers; an unused kind goes
// straight to the result. A clear item, and reset, sweep the valid RAM
// one entry a cycle over its whole depth, 2^(clog2(MAX_ROWS)+clog2(MAX_COLS))
// entries (65536 at the defaults), during which no item is taken; a clear then
// offers a result. Configuration writes are taken at any time. Results sit
// in an output register until taken.
// ----------------------------------------------------------------------------
module min_height_grid_rasterizer_unit
  import mhgr_pkg::*;
#(
  parameter int MAX_ROWS   = 256,
  parameter int MAX_COLS   = 256,
  parameter int COORD_BITS = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [RIDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  mhgr_in_if.sink           in_ch,
  mhgr_out_if.source        out_ch
);
  localparam int RB    = $clog2(MAX_ROWS) > 0 ? $clog2(MAX_ROWS) : 1;
  localparam int CB    = $clog2(MAX_COLS) > 0 ? $clog2(MAX_COLS) : 1;
  localparam int AW    = RB + CB;
  localparam int DEPTH = 1 << AW;
  localparam int DIMW  = 13;

  // configuration registers
  logic signed [COORD_BITS-1:0] min_x, min_y;
  logic [CSIZE_W-1:0] bin_size;
  logic [GDIM_W-1:0]  rows_in_use, cols_in_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_x       <= '0;
      min_y       <= '0;
      bin_size    <= CSIZE_W'(100);
      rows_in_use <= GDIM_W'(256);
      cols_in_use <= GDIM_W'(256);
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_MIN_X:    min_x <= COORD_BITS'(cfg_data);
        REG_MIN_Y:    min_y <= COORD_BITS'(cfg_data);
        REG_BIN_SIZE: bin_size <= cfg_data[CSIZE_W-1:0];
        REG_ROWS:     rows_in_use <= cfg_data[GDIM_W-1:0];
        REG_COLS:     cols_in_use <= cfg_data[GDIM_W-1:0];
        default: ;
      endcase
    end
  end

  // effective grid: saturate into [1, MAX]
  logic [DIMW-1:0] nr, nc;
  logic [CSIZE_W-1:0] cs;
  always_comb begin
    nr = DIMW'(rows_in_use);
    if (nr == '0) nr = DIMW'(1);
    if (nr > DIMW'(MAX_ROWS)) nr = DIMW'(MAX_ROWS);
    nc = DIMW'(cols_in_use);
    if (nc == '0) nc = DIMW'(1);
    if (nc > DIMW'(MAX_COLS)) nc = DIMW'(MAX_COLS);
    cs = (bin_size == '0) ? CSIZE_W'(1) : bin_size;
  end

  // top_y - y: nr*cs fits 33 bits; plus two coords, TW bits suffice with COORD_BITS>=16
  localparam int TW = COORD_BITS + 3 > 34 ? COORD_BITS + 3 : 34;
  logic signed [TW-1:0] span_y, dx, dy;
  assign span_y = TW'($signed({1'b0, nr * TW'(cs)}));
  assign dx = TW'(in_ch.x_coord) - TW'(min_x);
  assign dy = TW'(min_y) + span_y - TW'(in_ch.y_coord);

  state_t state, state_next;

  // latched item
  kind_t                 kind;
  logic signed [COORD_BITS-1:0] z;
  logic [7:0]            rrow, rcol;
  logic                  div_start;
  logic                  dx_done, dy_done;
  logic signed [TW-1:0]  qx, qy;
  logic [AW-1:0]         clr_addr;
  logic [RB-1:0]         row_idx;
  logic [CB-1:0]         col_idx;
  logic                  in_grid;

  mhgr_divider #(.NUM_W(TW), .DEN_W(CSIZE_W)) u_div_x (
    .clk, .rst, .start(div_start), .num(dx), .den(cs), .done(dx_done), .quo(qx)
  );
  mhgr_divider #(.NUM_W(TW), .DEN_W(CSIZE_W)) u_div_y (
    .clk, .rst, .start(div_start), .num(dy), .den(cs), .done(dy_done), .quo(qy)
  );

  // RAMs
  logic                  h_we, f_we, f_wd;
  logic [AW-1:0]         addr;
  logic [COORD_BITS-1:0] h_rd;
  logic                  f_rd;

  mhgr_ram #(.WIDTH(COORD_BITS), .DEPTH(DEPTH)) u_height (
    .clk, .we(h_we), .addr(addr), .wdata(z), .rdata(h_rd)
  );
  mhgr_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_filled (
    .clk, .we(f_we), .addr(addr), .wdata(f_wd), .rdata(f_rd)
  );

  logic take_item;
  assign take_item = in_ch.valid && in_ch.ready;
  logic lower;
  assign lower = !f_rd || (z < $signed(h_rd));

  // clamp quotients into grid
  logic [DIMW-1:0] ccol, crow;
  always_comb begin
    if (qx < 0) ccol = '0;
    else if (qx > TW'(nc) - 1) ccol = nc - 1'b1;
    else ccol = DIMW'(qx);
    if (qy < 0) crow = '0;
    else if (qy > TW'(nr) - 1) crow = nr - 1'b1;
    else crow = DIMW'(qy);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_INIT, ST_CLR: if (clr_addr == AW'(DEPTH - 1)) begin
        state_next = (state == ST_INIT) ? ST_IDLE : ST_OUT;
      end
      ST_IDLE: if (take_item) begin
        case (kind_t'(in_ch.kind))
          KIND_POINT: state_next = ST_DIV;
          KIND_READ:  state_next = ST_RD;
          KIND_CLEAR: state_next = ST_CLR;
          default:    state_next = ST_OUT;
        endcase
      end
      ST_DIV: if (dx_done && dy_done) state_next = ST_RD;
      ST_RD:  state_next = ST_WB;
      ST_WB:  state_next = ST_OUT;
      ST_OUT: if (out_ch.ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs of the controller
  always_comb begin
    in_ch.ready  = (state == ST_IDLE);
    out_ch.valid = (state == ST_OUT);
    div_start    = take_item && (kind_t'(in_ch.kind) == KIND_POINT);
    h_we = 1'b0;
    f_we = 1'b0;
    f_wd = 1'b0;
    addr = {row_idx, col_idx};
    if (state == ST_INIT || state == ST_CLR) begin
      addr = clr_addr;
      f_we = 1'b1;
    end else if (state == ST_WB && kind == KIND_POINT && lower) begin
      h_we = 1'b1;
      f_we = 1'b1;
      f_wd = 1'b1;
    end
  end

  // datapath registers
  logic [7:0]  o_row, o_col;
  logic [31:0] o_z;
  logic        o_valid, o_low;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_INIT;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == ST_INIT || state == ST_CLR) clr_addr <= clr_addr + 1'b1;
    end
    if (take_item) begin
      kind <= kind_t'(in_ch.kind);
      z    <= in_ch.z_coord;
      rrow <= in_ch.read_row;
      rcol <= in_ch.read_col;
      row_idx <= RB'(in_ch.read_row);
      col_idx <= CB'(in_ch.read_col);
      in_grid <= (DIMW'(in_ch.read_row) < nr) && (DIMW'(in_ch.read_col) < nc);
      o_row <= '0; o_col <= '0; o_z <= '0; o_valid <= 1'b0; o_low <= 1'b0;
    end
    if (state == ST_DIV && dx_done && dy_done) begin
      row_idx <= RB'(crow);
      col_idx <= CB'(ccol);
    end
    if (state == ST_WB) begin
      if (kind == KIND_POINT) begin
        o_row   <= 8'(row_idx);
        o_col   <= 8'(col_idx);
        o_valid <= 1'b1;
        o_low   <= lower;
        o_z     <= lower ? 32'(z) : 32'($signed(h_rd));
      end else begin
        o_row   <= rrow;
        o_col   <= rcol;
        o_valid <= in_grid && f_rd;
        o_z     <= (in_grid && f_rd) ? 32'($signed(h_rd)) : '0;
      end
    end
  end

  assign out_ch.cell_row   = o_row;
  assign out_ch.cell_col   = o_col;
  assign out_ch.cell_min_z = o_z;
  assign out_ch.cell_valid = o_valid;
  assign out_ch.lowered    = o_low;
endmodule

/* rtl/core/mhgr_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhgr_ram: generic single-port RAM
// One write or read per cycle, read data registered.
// ----------------------------------------------------------------------------
module mhgr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

/* rtl/core/mhgr_divider.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhgr_divider: iterative floor divider
// Signed dividend over positive divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mhgr_divider #(
  parameter int NUM_W = 34,
  parameter int DEN_W = 20
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [NUM_W-1:0] num,
  input  logic [DEN_W-1:0]        den,
  output logic                    done,
  output logic signed [NUM_W-1:0] quo
);
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] q;
  logic [DEN_W:0]   rem;
  logic [DEN_W-1:0] d;
  logic             neg;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DEN_W:0]   trial;
  logic [NUM_W-1:0] mag;

  // floor(a/b) for a<0 is -(floor((-a-1)/b)) - 1, i.e. ~((~a)/b)
  assign mag   = num[NUM_W-1] ? ~num : num;
  assign trial = {rem[DEN_W-1:0], q[NUM_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
        q    <= mag;
        rem  <= '0;
        d    <= den;
        neg  <= num[NUM_W-1];
      end else if (busy) begin
        if (trial >= {1'b0, d}) begin
          rem <= trial - {1'b0, d};
          q   <= {q[NUM_W-2:0], 1'b1};
        end else begin
          rem <= trial;
          q   <= {q[NUM_W-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quo = neg ? ~q : q;
endmodule
